// ===== rtl/core/pcfc_pkg.sv =====
package pcfc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int QW         = FRAC_BITS + 1;    // unit component magnitude bits
  localparam int SW         = 64 - FRAC_BITS;   // scaled product magnitude bits
  localparam int ACC_W      = SW + 2;           // signed sum of two scaled values
  localparam int ROOT_ITERS = 32;
  localparam int CNT_W      = 6;

  typedef struct packed {
    logic               op;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] box_x_min;
    logic signed [31:0] box_x_max;
    logic signed [31:0] box_top_y;
    logic signed [31:0] box_z_min;
    logic signed [31:0] box_z_max;
  } pcfc_in_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic signed [31:0] force_x;
    logic signed [31:0] force_y;
    logic signed [31:0] force_z;
  } pcfc_out_t;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_ENTER = 2'd1,
    EV_HOLD  = 2'd2,
    EV_EXIT  = 2'd3
  } event_t;

  typedef enum logic [1:0] {
    CFG_SPRING   = 2'd0,
    CFG_DAMPING  = 2'd1,
    CFG_FRICTION = 2'd2
  } cfg_index_t;

  typedef enum logic {
    RD_ROOT = 1'b0,
    RD_DIV  = 1'b1
  } rd_mode_t;

  typedef struct packed {
    logic     start;
    rd_mode_t mode;
  } rd_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rd_stat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIFF,
    ST_NORM,
    ST_SQ,
    ST_ROOT_GO,
    ST_ROOT_WAIT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FORCE,
    ST_ZERO,
    ST_LIM,
    ST_DY,
    ST_CONE,
    ST_DONE
  } state_t;

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(32'sh7fffffff);
    lo = -ACC_W'(33'sh080000000);
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // signed view of a product divided by 2^FRAC_BITS, negated when neg is set
  function automatic logic signed [ACC_W-1:0] scaled(input logic [63:0] prod, input logic neg);
    logic signed [ACC_W-1:0] m;
    m = signed'({2'b00, prod[63:FRAC_BITS]});
    return neg ? -m : m;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    return v[32] ? 33'(-v) : 33'(v);
  endfunction

endpackage

// ===== rtl/core/pcfc_mul.sv =====
module pcfc_mul (
  input  logic        clk,
  input  logic [30:0] gain,
  input  logic [32:0] mag,
  output logic [63:0] prod
);
  import pcfc_pkg::*;

  always_ff @(posedge clk) begin
    prod <= {33'b0, gain} * {31'b0, mag};
  end

endmodule

// ===== rtl/core/pcfc_rootdiv.sv =====
module pcfc_rootdiv (
  input  logic              clk,
  input  logic              rst,
  input  pcfc_pkg::rd_cmd_t cmd,
  input  logic [63:0]       operand,
  input  logic [31:0]       divisor,
  output pcfc_pkg::rd_stat_t stat,
  output logic [31:0]       result
);
  import pcfc_pkg::*;

  logic [63:0]      acc;
  logic [63:0]      root;
  logic [63:0]      bitm;
  logic [31:0]      divisor_r;
  logic [CNT_W-1:0] cnt;
  logic             first;
  logic             busy;
  logic             done;
  rd_mode_t         mode_r;
  logic [63:0]      cand;
  logic [63:0]      opb;
  logic [64:0]      diff;
  logic             ge;

  // one shared subtract and compare serves both the root and the divide step
  always_comb begin
    cand = (mode_r == RD_DIV && !first) ? {acc[62:0], 1'b0} : acc;
    opb  = (mode_r == RD_ROOT) ? root + bitm : {32'b0, divisor_r};
    diff = {1'b0, cand} - {1'b0, opb};
    ge   = ~diff[64];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= (cmd.mode == RD_ROOT) ? CNT_W'(ROOT_ITERS) : CNT_W'(QW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      acc       <= operand;
      root      <= '0;
      bitm      <= 64'h4000_0000_0000_0000;
      divisor_r <= divisor;
      mode_r    <= cmd.mode;
      first     <= 1'b1;
    end else if (busy) begin
      first <= 1'b0;
      if (mode_r == RD_ROOT) begin
        acc  <= ge ? diff[63:0] : acc;
        root <= ge ? (root >> 1) + bitm : root >> 1;
        bitm <= bitm >> 2;
      end else begin
        acc  <= ge ? diff[63:0] : cand;
        root <= {root[62:0], ge};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = root[31:0];

endmodule

// ===== rtl/core/penalty_contact_friction_cone.sv =====
// channel | direction | handshake             | word
// in      | input     | in_valid / in_ready   | in_data   (op, position, velocity, box bounds)
// out     | output    | out_valid / out_ready | out_data  (event, force x/y/z)
// cfg     | input     | cfg_we                | cfg_index, cfg_data (31 bit gains)
//
// one word at a time; a word outside the box goes from the test straight to the output store,
// one whose anchor equals the position skips to the force step, and any other contact
// also takes up to 30 one-bit normalize shifts, the 32-step square root and three
// (FRAC_BITS+1)-step divides on the shared root/divide unit.
// rst is synchronous; it restores gains and clears contact, anchor and previous position.
// a finished word sits in the output register; a new word is taken while it waits,
// and only the final store stalls when the output register is still full.
module penalty_contact_friction_cone (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcfc_pkg::pcfc_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pcfc_pkg::pcfc_out_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);
  import pcfc_pkg::*;

  state_t state, state_next;

  // configuration
  logic [30:0] spring_gain;
  logic [30:0] damping_gain;
  logic [30:0] friction_coeff;

  // persistent contact state
  logic               in_contact;
  logic signed [31:0] anchor [3];
  logic signed [31:0] prev [3];

  // per word working registers
  pcfc_in_t           item;
  event_t             ev;
  logic [32:0]        m [3];
  logic               dneg [3];
  logic [63:0]        sum;
  logic [31:0]        len;
  logic [QW-1:0]      uq [3];
  logic signed [ACC_W-1:0] sp;
  logic signed [31:0] fr [3];
  logic [SW-1:0]      lim;
  logic [2:0]         cnt;

  // shared units
  logic [30:0] mul_gain;
  logic [32:0] mul_mag;
  logic [63:0] prod;
  rd_cmd_t     rd_cmd;
  rd_stat_t    rd_stat;
  logic [63:0] rd_operand;
  logic [31:0] rd_result;
  logic        out_load;

  // combinational helpers
  logic               in_box;
  logic signed [32:0] d [3];
  logic               d_zero;
  logic               norm_big;
  logic               norm_small;
  logic signed [31:0] pos [3];
  logic signed [31:0] vel [3];
  logic signed [32:0] dy;
  logic signed [ACC_W-1:0] delta;
  logic signed [ACC_W-1:0] lim_s;
  logic signed [ACC_W-1:0] f0_s;
  logic [1:0]         j_issue;
  logic [1:0]         j_use;
  logic [2:0]         idx_use;

  pcfc_mul u_mul (
    .clk  (clk),
    .gain (mul_gain),
    .mag  (mul_mag),
    .prod (prod)
  );

  pcfc_rootdiv u_rootdiv (
    .clk     (clk),
    .rst     (rst),
    .cmd     (rd_cmd),
    .operand (rd_operand),
    .divisor (len),
    .stat    (rd_stat),
    .result  (rd_result)
  );

  always_comb begin
    pos[0] = item.pos_x;
    pos[1] = item.pos_y;
    pos[2] = item.pos_z;
    vel[0] = item.vel_x;
    vel[1] = item.vel_y;
    vel[2] = item.vel_z;
    in_box = ($signed(item.pos_x) > $signed(item.box_x_min)) &&
             ($signed(item.pos_x) < $signed(item.box_x_max)) &&
             ($signed(item.pos_y) < $signed(item.box_top_y));
    if (!item.op) begin
      in_box = in_box && ($signed(item.pos_z) > $signed(item.box_z_min)) &&
               ($signed(item.pos_z) < $signed(item.box_z_max));
    end
    for (int i = 0; i < 3; i++) begin
      d[i] = 33'(anchor[i]) - 33'(pos[i]);
    end
    d_zero     = (d[0] == '0) && (d[1] == '0) && (d[2] == '0);
    norm_big   = |{m[0][32:31], m[1][32:31], m[2][32:31]};
    norm_small = ~|{m[0][32:30], m[1][32:30], m[2][32:30]};
    dy         = 33'(anchor[1]) - 33'(item.pos_y);
    delta      = scaled(prod, dy[32]);
    lim_s      = signed'({2'b00, lim});
    f0_s       = ACC_W'(fr[0]);
    j_issue    = cnt[2:1];
    idx_use    = cnt - 3'd1;
    j_use      = idx_use[2:1];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_TEST;
      ST_TEST:      state_next = in_box ? ST_DIFF : ST_DONE;
      ST_DIFF:      state_next = d_zero ? ST_FORCE : ST_NORM;
      ST_NORM:      if (!norm_big && !norm_small) state_next = ST_SQ;
      ST_SQ:        if (cnt == 3'd3) state_next = ST_ROOT_GO;
      ST_ROOT_GO:   state_next = ST_ROOT_WAIT;
      ST_ROOT_WAIT: if (rd_stat.done) state_next = ST_DIV_GO;
      ST_DIV_GO:    state_next = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (rd_stat.done) state_next = (cnt == 3'd2) ? ST_FORCE : ST_DIV_GO;
      ST_FORCE:     if (cnt == 3'd6) state_next = ST_ZERO;
      ST_ZERO:      state_next = ST_LIM;
      ST_LIM:       state_next = ST_DY;
      ST_DY:        state_next = ST_CONE;
      ST_CONE:      state_next = ST_DONE;
      ST_DONE:      if (!out_valid || out_ready) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // unit operands and handshake
  always_comb begin
    in_ready   = (state == ST_IDLE);
    out_load   = (state == ST_DONE) && (!out_valid || out_ready);
    mul_gain   = '0;
    mul_mag    = '0;
    rd_cmd     = '{start: 1'b0, mode: RD_ROOT};
    rd_operand = sum;
    case (state)
      ST_SQ: begin
        if (cnt < 3'd3) begin
          mul_gain = m[cnt[1:0]][30:0];
          mul_mag  = m[cnt[1:0]];
        end
      end
      ST_ROOT_GO: begin
        rd_cmd = '{start: 1'b1, mode: RD_ROOT};
      end
      ST_DIV_GO: begin
        rd_cmd     = '{start: 1'b1, mode: RD_DIV};
        rd_operand = {31'b0, m[cnt[1:0]]};
      end
      ST_FORCE: begin
        if (cnt < 3'd6) begin
          if (!cnt[0]) begin
            mul_gain = spring_gain;
            mul_mag  = 33'(uq[j_issue]);
          end else begin
            mul_gain = damping_gain;
            mul_mag  = mag33(33'(vel[j_issue]));
          end
        end
      end
      ST_LIM: begin
        mul_gain = friction_coeff;
        mul_mag  = {1'b0, fr[1]};
      end
      ST_DY: begin
        mul_gain = friction_coeff;
        mul_mag  = mag33(dy);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      spring_gain    <= 31'(1 << FRAC_BITS);
      damping_gain   <= '0;
      friction_coeff <= 31'(1 << FRAC_BITS);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SPRING:   spring_gain    <= cfg_data;
        CFG_DAMPING:  damping_gain   <= cfg_data;
        CFG_FRICTION: friction_coeff <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.event_res <= ev;
      out_data.force_x   <= fr[0];
      out_data.force_y   <= fr[1];
      out_data.force_z   <= fr[2];
    end
  end

  // contact state and the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      in_contact <= 1'b0;
      cnt        <= '0;
      for (int i = 0; i < 3; i++) begin
        anchor[i] <= '0;
        prev[i]   <= '0;
      end
    end else begin
      case (state)
        ST_TEST: begin
          if (in_box) begin
            if (!in_contact) begin
              in_contact <= 1'b1;
              for (int i = 0; i < 3; i++) anchor[i] <= prev[i];
            end
          end else begin
            in_contact <= 1'b0;
          end
          for (int i = 0; i < 3; i++) prev[i] <= pos[i];
        end
        ST_NORM: cnt <= '0;
        ST_DIFF: cnt <= '0;
        ST_SQ:   cnt <= cnt + 3'd1;
        ST_ROOT_GO: cnt <= '0;
        ST_DIV_WAIT: begin
          if (rd_stat.done) begin
            cnt <= (cnt == 3'd2) ? 3'd0 : cnt + 3'd1;
          end
        end
        ST_FORCE: cnt <= cnt + 3'd1;
        ST_CONE: begin
          // a clamp slides the anchor along x
          if (f0_s > lim_s) begin
            anchor[0] <= sat32(ACC_W'(item.pos_x) + delta);
          end else if (f0_s < -lim_s) begin
            anchor[0] <= sat32(ACC_W'(item.pos_x) - delta);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) item <= in_data;
      end
      ST_TEST: begin
        if (in_box) begin
          ev <= in_contact ? EV_HOLD : EV_ENTER;
        end else begin
          ev <= in_contact ? EV_EXIT : EV_NONE;
        end
        for (int i = 0; i < 3; i++) fr[i] <= '0;
      end
      ST_DIFF: begin
        for (int i = 0; i < 3; i++) begin
          m[i]    <= mag33(d[i]);
          dneg[i] <= d[i][32];
          uq[i]   <= '0;
        end
      end
      ST_NORM: begin
        // bring the largest magnitude into [2^30, 2^31)
        if (norm_big) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] >> 1;
        end else if (norm_small) begin
          for (int i = 0; i < 3; i++) m[i] <= m[i] << 1;
        end
        sum <= '0;
      end
      ST_SQ: begin
        if (cnt != 3'd0) sum <= sum + prod;
      end
      ST_ROOT_WAIT: begin
        if (rd_stat.done) len <= rd_result;
      end
      ST_DIV_WAIT: begin
        if (rd_stat.done) uq[cnt[1:0]] <= rd_result[QW-1:0];
      end
      ST_FORCE: begin
        if (cnt != 3'd0) begin
          if (!idx_use[0]) begin
            sp <= scaled(prod, dneg[j_use]);
          end else begin
            fr[j_use] <= sat32(sp - scaled(prod, vel[j_use][31]));
          end
        end
      end
      ST_ZERO: begin
        if (fr[1] < 0) begin
          for (int i = 0; i < 3; i++) fr[i] <= '0;
        end
      end
      ST_DY: begin
        lim <= prod[63:FRAC_BITS];
      end
      ST_CONE: begin
        if (f0_s > lim_s) begin
          fr[0] <= sat32(lim_s);
        end else if (f0_s < -lim_s) begin
          fr[0] <= sat32(-lim_s);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== bench/tb_top.sv =====
module tb_top;
  import pcfc_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  pcfc_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  pcfc_out_t out_data;
  logic      cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;

  always #1 clk = ~clk;

  penalty_contact_friction_cone dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor state: gains and contact memory
  longint unsigned k_gain, c_gain, mu_gain;
  logic      touching;
  longint    anchor[3];
  longint    last_pos[3];

  pcfc_out_t expected_words[$];
  int        fail_count = 0;
  longint    cycle_count = 0;
  logic      quiet = 1'b0;  // no idling stretch
  localparam longint CYCLE_LIMIT = 3000000;

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned magnitude(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  // gain*v/2^FRAC_BITS truncated toward zero
  function automatic longint gain_mul(longint unsigned g, longint v);
    longint unsigned p;
    p = (g * magnitude(v)) >> FRAC_BITS;
    return v < 0 ? -longint'(p) : longint'(p);
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  task automatic direction_to_anchor(input longint d[3], output longint u[3]);
    longint unsigned m[3], mx, sum, len, q;
    mx = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      m[i] = magnitude(d[i]);
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) begin
      u = '{0, 0, 0};
      return;
    end
    while (mx >= (64'd1 << 31)) begin
      for (int i = 0; i < 3; i++) m[i] >>= 1;
      mx >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) m[i] <<= 1;
      mx <<= 1;
    end
    for (int i = 0; i < 3; i++) sum += m[i] * m[i];
    len = int_root(sum);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] << FRAC_BITS) / len;
      u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
    end
  endtask

  task automatic predict_contact(input pcfc_in_t w, output pcfc_out_t r);
    longint p[3], v[3], d[3], u[3], f[3], lim, dy, delta;
    logic in_box;
    event_t ev;
    p = '{w.pos_x, w.pos_y, w.pos_z};
    v = '{w.vel_x, w.vel_y, w.vel_z};
    f = '{0, 0, 0};
    in_box = w.pos_x > w.box_x_min && w.pos_x < w.box_x_max && w.pos_y < w.box_top_y;
    if (!w.op) in_box = in_box && w.pos_z > w.box_z_min && w.pos_z < w.box_z_max;
    if (in_box) begin
      if (!touching) begin
        touching = 1'b1;
        ev = EV_ENTER;
        anchor = last_pos;
      end else ev = EV_HOLD;
      for (int i = 0; i < 3; i++) d[i] = anchor[i] - p[i];
      direction_to_anchor(d, u);
      for (int i = 0; i < 3; i++) f[i] = clamp32(gain_mul(k_gain, u[i]) - gain_mul(c_gain, v[i]));
      if (f[1] < 0) f = '{0, 0, 0};
      lim = gain_mul(mu_gain, f[1]);
      if (f[0] < -lim || f[0] > lim) begin
        dy = anchor[1] - p[1];
        delta = gain_mul(mu_gain, dy);
        if (f[0] < -lim) begin
          f[0] = clamp32(-lim);
          delta = -delta;
        end else f[0] = clamp32(lim);
        anchor[0] = clamp32(p[0] + delta);
      end
    end else begin
      ev = touching ? EV_EXIT : EV_NONE;
      touching = 1'b0;
    end
    last_pos = p;
    r.event_res = ev;
    r.force_x = f[0][31:0];
    r.force_y = f[1][31:0];
    r.force_z = f[2][31:0];
  endtask

  task automatic write_gain(input cfg_index_t idx, input logic [30:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_SPRING:   k_gain = val;
      CFG_DAMPING:  c_gain = val;
      CFG_FRICTION: mu_gain = val;
      default: ;
    endcase
  endtask

  // send one word; at entry we are just past a falling edge, and valid is left
  // high after the accept until the next word or an explicit stop
  task automatic send_word(input pcfc_in_t w, input logic has_fixed, input pcfc_out_t fixed);
    pcfc_out_t r;
    while (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_contact(w, r);
    if (has_fixed && r != fixed) begin
      $error("directed row: predicted %h, typed %h", r, fixed);
      fail_count++;
    end
    expected_words.push_back(has_fixed ? fixed : r);
    @(negedge clk);
  endtask

  task automatic drain_block();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  // output side: random stalls, compare field by field
  always @(negedge clk) out_ready <= quiet || ($urandom_range(99) >= 22);

  always @(posedge clk) begin
    pcfc_out_t e;
    cycle_count <= cycle_count + 1;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word %h", out_data);
        fail_count++;
      end else begin
        e = expected_words.pop_front();
        if (out_data.event_res !== e.event_res) begin
          $error("event_res expected %0d actual %0d", e.event_res, out_data.event_res);
          fail_count++;
        end
        if (out_data.force_x !== e.force_x) begin
          $error("force_x expected %0d actual %0d", e.force_x, out_data.force_x);
          fail_count++;
        end
        if (out_data.force_y !== e.force_y) begin
          $error("force_y expected %0d actual %0d", e.force_y, out_data.force_y);
          fail_count++;
        end
        if (out_data.force_z !== e.force_z) begin
          $error("force_z expected %0d actual %0d", e.force_z, out_data.force_z);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // random coordinate: mostly modest, sometimes full range
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  function automatic pcfc_in_t rand_word(input logic inside_bias);
    pcfc_in_t w;
    w.op = $urandom_range(1);
    w.pos_x = rand_coord();
    w.pos_y = rand_coord();
    w.pos_z = rand_coord();
    w.vel_x = rand_coord();
    w.vel_y = rand_coord();
    w.vel_z = rand_coord();
    if (inside_bias) begin
      // box around the vertex, with a random margin below x and the other bounds at the range limits
      w.box_x_min = 33'(w.pos_x) - 33'($urandom_range(65536) + 1) < -33'sd2147483648 ?
                    32'sh80000000 : w.pos_x - 32'($urandom_range(65536) + 1);
      w.box_x_max = w.pos_x == 32'sh7fffffff ? w.pos_x : 32'sh7fffffff;
      w.box_top_y = w.pos_y == 32'sh7fffffff ? w.pos_y : 32'sh7fffffff;
      w.box_z_min = 32'sh80000000;
      w.box_z_max = 32'sh7fffffff;
      if ($urandom_range(9) == 0) w.box_z_max = w.pos_z;
    end else begin
      w.box_x_min = rand_coord();
      w.box_x_max = rand_coord();
      w.box_top_y = rand_coord();
      w.box_z_min = rand_coord();
      w.box_z_max = rand_coord();
    end
    return w;
  endfunction

  typedef struct {
    pcfc_in_t  word;
    logic      fixed;
    pcfc_out_t result;
  } stim_row_t;

  function automatic pcfc_in_t box_word(input logic o, input int x, input int y, input int z,
                                        input int vx, input int vy, input int vz);
    pcfc_in_t w;
    w = '{o, x, y, z, vx, vy, vz, -32'sh00100000, 32'sh00100000, 32'sh00100000,
          -32'sh00100000, 32'sh00100000};
    return w;
  endfunction

  initial begin
    stim_row_t rows[$];
    pcfc_in_t w;
    int n;
    k_gain = 64'd1 << FRAC_BITS;
    c_gain = 0;
    mu_gain = 64'd1 << FRAC_BITS;
    touching = 1'b0;
    anchor = '{0, 0, 0};
    last_pos = '{0, 0, 0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // outside the box: no contact
    rows.push_back('{box_word(0, 32'sh00200000, 0, 0, 0, 0, 0), 1, '{EV_NONE, 0, 0, 0}});
    // zero force on entry: the anchor comes from the previous position and the x pull clamps to zero
    rows.push_back('{box_word(0, 0, 0, 0, 0, 0, 0), 1, '{EV_ENTER, 0, 0, 0}});
    // held, pushed down: unit y is +1.0
    rows.push_back('{box_word(0, 0, -32'sh00010000, 0, 0, 0, 0), 1,
                     '{EV_HOLD, 0, 32'sh00010000, 0}});
    // sideways pull with zero y: clamp to zero slides anchor
    rows.push_back('{box_word(1, 32'sh00010000, 0, 32'sh7fffffff, 0, 0, 0), 0, '0});
    rows.push_back('{box_word(0, 32'sh00010000, 32'sh00050000, 0, 0, 0, 0), 0, '0});
    // exit
    rows.push_back('{box_word(0, 32'sh00200000, 0, 0, 0, 0, 0), 1, '{EV_EXIT, 0, 0, 0}});
    // planar test with z far outside
    rows.push_back('{box_word(1, 0, 0, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0), 0, '0});
    rows.push_back('{box_word(1, -32'sh00080000, -32'sh00080000, 32'sh7fffffff,
                              32'sh80000000, 32'sh7fffffff, 32'sh7fffffff), 0, '0});
    // op 0 with z at the exclusive bound: outside
    rows.push_back('{box_word(0, 0, 0, 32'sh00100000, 0, 0, 0), 1, '{EV_EXIT, 0, 0, 0}});
    // extreme box bounds, vertex at extremes
    w = '{0, 32'sh80000000, 32'sh80000000, 32'sh80000000, -1, -1, -1,
          32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    rows.push_back('{w, 1, '{EV_NONE, 0, 0, 0}});
    w = '{0, 32'sh7ffffffe, 32'sh80000000, 32'sh7ffffffe, -1, -1, -1,
          32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    rows.push_back('{w, 0, '0});
    w.pos_x = 32'sh80000001;
    w.pos_y = 32'sh7ffffffe;
    rows.push_back('{w, 0, '0});
    foreach (rows[i]) send_word(rows[i].word, rows[i].fixed, rows[i].result);
    drain_block();

    // large gains: saturation of forces
    write_gain(CFG_SPRING, 31'h7fffffff);
    write_gain(CFG_DAMPING, 31'h7fffffff);
    write_gain(CFG_FRICTION, 31'h7fffffff);
    for (int i = 0; i < 12; i++) send_word(rand_word(i != 5), 0, '0);
    drain_block();

    // zero gains everywhere
    write_gain(CFG_SPRING, '0);
    write_gain(CFG_DAMPING, '0);
    write_gain(CFG_FRICTION, '0);
    for (int i = 0; i < 8; i++) send_word(rand_word(1), 0, '0);
    drain_block();

    // random phases with random gains, small and large
    for (int ph = 0; ph < 8; ph++) begin
      write_gain(CFG_SPRING, 31'(ph[0] ? $urandom : $urandom_range(32'h00040000)));
      write_gain(CFG_DAMPING, 31'(ph[1] ? $urandom : $urandom_range(32'h00010000)));
      write_gain(CFG_FRICTION, 31'(ph[2] ? $urandom : $urandom_range(32'h00020000)));
      quiet = (ph == 3);
      n = 0;
      while (n < 250) begin
        // runs of well-formed contact bursts, mixed with noise
        for (int j = $urandom_range(6); j >= 0; j--) begin
          send_word(rand_word($urandom_range(99) < 75), 0, '0);
          n++;
        end
        if (ph == 5 && n < 20) begin
          // hold off until every result is back
          in_valid <= 1'b0;
          do @(negedge clk); while (expected_words.size() != 0);
        end
      end
      quiet = 1'b0;
      drain_block();
    end

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
